// ===== src/tsms_pkg.sv =====
`timescale 1ns / 1ps
package tsms_pkg;

	localparam int FIELD_BITS = 32;
	localparam int SLICE_BITS = 8;
	localparam int CHAN_OUT_BITS = 3;
	localparam int CHCOUNT_BITS = 4;
	localparam int MASK_BITS = 8;
	localparam int SLICES_BITS = 64;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 64;
	localparam int MAPPED_CHANNELS = 8;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MUST_FINISH   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SLICE_LENGTHS = 2'd2;

	typedef struct packed {
		logic                         timer_expired;
		logic                         conv_done;
		logic signed [FIELD_BITS-1:0] conv_value;
	} poll_t;

	typedef struct packed {
		logic                         start_timer;
		logic [SLICE_BITS-1:0]        timer_slice;
		logic                         start_conversion;
		logic [CHAN_OUT_BITS-1:0]     active_channel;
		logic                         result_valid;
		logic signed [FIELD_BITS-1:0] result_value;
	} report_t;

endpackage

// ===== src/time_sliced_measurement_sequencer_unit.sv =====
`timescale 1ns / 1ps
// Round-robin measurement sequencer: each accepted poll gives exactly one report. A poll
// that does not end a slice with samples taken has its report written to the buffer when
// it is accepted; the report moves on to the output register once that is free, and the
// next poll is held off while the buffer is full. A poll that ends a slice with samples
// runs the bit-serial divider: the average (SAMPLE_BITS capped at 32) reaches the buffer
// when the division ends, and the next poll is held off until then. A one-item buffer in
// front of the output register lets a poll be taken while a report waits. Configuration
// is accepted every cycle; there is no clearing pass after reset.
module time_sliced_measurement_sequencer_unit #(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 32,
	parameter int COUNT_BITS   = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    poll_valid,
	output logic                                    poll_stall,
	input  tsms_pkg::poll_t                         poll_data,
	output logic                                    rpt_valid,
	input  logic                                    rpt_stall,
	output tsms_pkg::report_t                       rpt_data,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [tsms_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [tsms_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	import tsms_pkg::*;

	localparam int SB       = (SAMPLE_BITS < FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
	localparam int SUM_BITS = SB + COUNT_BITS;
	localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int N_W      = CHCOUNT_BITS + 1;
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic [CHCOUNT_BITS-1:0] cnt_q;
	logic [MASK_BITS-1:0]    mask_q;
	logic [SLICES_BITS-1:0]  slices_q;

	logic                    st_q;
	logic                    running_q;
	logic [CH_W-1:0]         cur_q;
	logic [CH_W-1:0]         fin_ch_q;
	logic [MAX_CHANNELS-1:0] open_q;
	logic [MAX_CHANNELS-1:0] pend_q;
	logic signed [SUM_BITS-1:0] sum_q [MAX_CHANNELS];
	logic [COUNT_BITS-1:0]   count_q [MAX_CHANNELS];
	logic signed [SB-1:0]    last_q [MAX_CHANNELS];

	report_t res_q;
	logic    res_full_q;
	report_t rpt_q;
	logic    rpt_valid_q;

	logic                 accept;
	logic [N_W-1:0]       cnt_ext;
	logic [N_W-1:0]       n_eff;
	logic [CH_W-1:0]      c_run;
	logic [CH_W-1:0]      c_idle;
	logic [CH_W-1:0]      c;
	logic [CH_W-1:0]      c_nxt;
	logic [N_W-1:0]       c_ext;
	logic                 in_map;
	logic                 mf;
	logic [SLICE_BITS-1:0] slice_v;
	logic                 open_c;
	logic                 pend_c;
	logic signed [SUM_BITS-1:0] sum_c;
	logic [COUNT_BITS-1:0] cnt_c;
	logic signed [SB-1:0] last_c;
	logic signed [SB-1:0] smp;
	logic signed [SB-1:0] half_tmp;
	logic signed [SB-1:0] half_v;
	logic signed [SUM_BITS-1:0] sum_new;
	logic [COUNT_BITS-1:0] cnt_new;
	logic act_start_t;
	logic act_start_c;
	logic act_add;
	logic act_close;
	logic act_pend;
	logic finished;
	logic need_div;
	logic div_start;
	logic div_done;
	logic signed [SB-1:0] div_q;

	assign accept    = poll_valid & ~poll_stall;
	assign poll_stall = (st_q != ST_IDLE) | res_full_q;
	assign cfg_ready = 1'b1;

	// effective channel count and channel selection
	always_comb begin
		cnt_ext = {1'b0, cnt_q};
		if (cnt_q == '0) begin
			n_eff = N_W'(1);
		end else if (cnt_ext > N_W'(MAX_CHANNELS)) begin
			n_eff = N_W'(MAX_CHANNELS);
		end else begin
			n_eff = cnt_ext;
		end
		c_run  = (N_W'(cur_q) >= N_W'(MAX_CHANNELS)) ? '0 : cur_q;
		c_idle = (N_W'(c_run) >= n_eff) ? '0 : c_run;
		c      = running_q ? c_run : c_idle;
		c_nxt  = ((N_W'(c) + 1'b1) >= n_eff) ? '0 : (c + 1'b1);
		c_ext  = N_W'(c);
		in_map = c_ext < N_W'(MAPPED_CHANNELS);
		mf      = in_map & mask_q[c_ext[2:0]];
		slice_v = in_map ? slices_q[{c_ext[2:0], 3'b000} +: SLICE_BITS] : '0;
	end

	assign open_c = open_q[c];
	assign pend_c = pend_q[c];
	assign sum_c  = sum_q[c];
	assign cnt_c  = count_q[c];
	assign last_c = last_q[c];
	assign smp    = poll_data.conv_value[SB-1:0];

	// half of the last result, truncated toward zero
	assign half_tmp = last_c + SB'(last_c[SB-1]);
	assign half_v   = {half_tmp[SB-1], half_tmp[SB-1:1]};

	always_comb begin
		act_start_t = 1'b0;
		act_start_c = 1'b0;
		act_add     = 1'b0;
		act_close   = 1'b0;
		act_pend    = 1'b0;
		finished    = 1'b0;
		if (!running_q) begin
			act_start_t = 1'b1;
		end else if (poll_data.timer_expired && !pend_c) begin
			if (!mf || !open_c) begin
				finished = 1'b1;
			end else begin
				act_pend = 1'b1;
			end
		end else if (!open_c) begin
			act_start_c = 1'b1;
		end else if (poll_data.conv_done) begin
			act_close = 1'b1;
			act_add   = (cnt_c != {COUNT_BITS{1'b1}});
			finished  = pend_c;
		end
		sum_new  = act_add ? (sum_c + SUM_BITS'(smp)) : sum_c;
		cnt_new  = act_add ? (cnt_c + 1'b1) : cnt_c;
		need_div = finished && (cnt_new != '0);
	end

	assign div_start = accept & need_div;

	tsms_div #(
		.DVD_BITS (SUM_BITS),
		.DVS_BITS (COUNT_BITS),
		.Q_BITS   (SB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_new),
		.divisor  (cnt_new),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= CHCOUNT_BITS'(1);
			mask_q      <= '0;
			slices_q    <= '0;
			st_q        <= ST_IDLE;
			running_q   <= 1'b0;
			cur_q       <= '0;
			open_q      <= '0;
			pend_q      <= '0;
			res_full_q  <= 1'b0;
			rpt_valid_q <= 1'b0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				sum_q[i]   <= '0;
				count_q[i] <= '0;
				last_q[i]  <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_CHANNEL_COUNT: cnt_q    <= cfg_data[CHCOUNT_BITS-1:0];
					REG_MUST_FINISH:   mask_q   <= cfg_data[MASK_BITS-1:0];
					REG_SLICE_LENGTHS: slices_q <= cfg_data[SLICES_BITS-1:0];
					default: ;
				endcase
			end

			if (res_full_q && (!rpt_valid_q || !rpt_stall)) begin
				rpt_valid_q <= 1'b1;
				res_full_q  <= 1'b0;
			end else if (rpt_valid_q && !rpt_stall) begin
				rpt_valid_q <= 1'b0;
			end

			if (accept) begin
				cur_q <= finished ? c_nxt : c;
				if (act_start_t) begin
					running_q <= 1'b1;
				end
				if (act_start_c) begin
					open_q[c] <= 1'b1;
				end
				if (act_close) begin
					open_q[c] <= 1'b0;
				end
				if (act_pend) begin
					pend_q[c] <= 1'b1;
				end
				sum_q[c]   <= finished ? '0 : sum_new;
				count_q[c] <= finished ? '0 : cnt_new;
				if (finished) begin
					pend_q[c]  <= 1'b0;
					running_q  <= 1'b0;
					if (!need_div) begin
						last_q[c] <= half_v;
					end
				end
				if (need_div) begin
					st_q <= ST_DIV;
				end else begin
					res_full_q <= 1'b1;
				end
			end

			if (st_q == ST_DIV && div_done) begin
				last_q[fin_ch_q] <= div_q;
				res_full_q       <= 1'b1;
				st_q             <= ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fin_ch_q                 <= c;
			res_q.start_timer        <= act_start_t;
			res_q.timer_slice        <= act_start_t ? slice_v : '0;
			res_q.start_conversion   <= act_start_c;
			res_q.active_channel     <= c_ext[CHAN_OUT_BITS-1:0];
			res_q.result_valid       <= finished;
			res_q.result_value       <= finished ? FIELD_BITS'(half_v) : '0;
		end
		if (st_q == ST_DIV && div_done) begin
			res_q.result_value <= FIELD_BITS'(div_q);
		end
		if (res_full_q && (!rpt_valid_q || !rpt_stall)) begin
			rpt_q <= res_q;
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt_data  = rpt_q;

`ifndef SYNTH
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> st_q == ST_DIV)
		else $error("divider finished outside a division");

	a_no_buffer_during_div: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV |-> !res_full_q)
		else $error("report buffered while division runs");

	a_div_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> st_q == ST_DIV && !res_full_q)
		else $error("division start did not hold the report back");

	a_timer_or_result: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid |-> !(rpt_data.start_timer && rpt_data.result_valid))
		else $error("timer start and result in one report");

	a_slice_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && !rpt_data.start_timer |-> rpt_data.timer_slice == '0)
		else $error("slice length without timer start");
`endif

endmodule

// ===== src/tsms_div.sv =====
`timescale 1ns / 1ps
module tsms_div #(
	parameter int DVD_BITS = 48,
	parameter int DVS_BITS = 16,
	parameter int Q_BITS   = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [DVD_BITS-1:0] dividend,
	input  logic [DVS_BITS-1:0]        divisor,
	output logic                       done,
	output logic signed [Q_BITS-1:0]   quotient
);

	localparam int STEP_BITS = $clog2(DVD_BITS + 1);
	localparam logic [1:0] DV_IDLE = 2'd0;
	localparam logic [1:0] DV_ABS  = 2'd1;
	localparam logic [1:0] DV_RUN  = 2'd2;
	localparam logic [1:0] DV_SIGN = 2'd3;

	logic [1:0]              st_q;
	logic                    done_q;
	logic [STEP_BITS-1:0]    step_q;
	logic [DVD_BITS-1:0]     dvd_q;
	logic [DVS_BITS-1:0]     dvs_q;
	logic [DVS_BITS-1:0]     rem_q;
	logic                    neg_q;
	logic signed [Q_BITS-1:0] quot_q;

	logic [DVS_BITS:0]   rem_sh;
	logic [DVS_BITS+1:0] diff;
	logic                q_bit;

	// one quotient bit a cycle, restoring
	assign rem_sh = {rem_q, dvd_q[DVD_BITS-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign q_bit  = ~diff[DVS_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DV_IDLE;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= (st_q == DV_SIGN);
			unique case (st_q)
				DV_IDLE: begin
					if (start) begin
						st_q <= DV_ABS;
					end
				end
				DV_ABS: begin
					step_q <= STEP_BITS'(DVD_BITS - 1);
					st_q   <= DV_RUN;
				end
				DV_RUN: begin
					if (step_q == '0) begin
						st_q <= DV_SIGN;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				DV_SIGN: begin
					st_q <= DV_IDLE;
				end
				default: st_q <= DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			DV_IDLE: begin
				if (start) begin
					dvd_q <= dividend;
					neg_q <= dividend[DVD_BITS-1];
					dvs_q <= divisor;
				end
			end
			DV_ABS: begin
				dvd_q <= neg_q ? (~dvd_q + 1'b1) : dvd_q;
				rem_q <= '0;
			end
			DV_RUN: begin
				dvd_q <= {dvd_q[DVD_BITS-2:0], q_bit};
				rem_q <= q_bit ? diff[DVS_BITS-1:0] : rem_sh[DVS_BITS-1:0];
			end
			DV_SIGN: begin
				quot_q <= neg_q ? (~dvd_q[Q_BITS-1:0] + 1'b1) : dvd_q[Q_BITS-1:0];
			end
			default: ;
		endcase
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule
